// ===== rtl/core/imutcf_pkg.sv =====
// ----------------------------------------------------------------------------
// imutcf_pkg
// Shared types, constants and the arctangent table of the tilt filter.
// ----------------------------------------------------------------------------
`default_nettype none

package imutcf_pkg;

    // CORDIC depth and table length
    localparam int CORDIC_ITERATIONS = 16;
    localparam int TABLE_LEN         = 24;
    localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < TABLE_LEN) ?
                                       CORDIC_ITERATIONS : TABLE_LEN;
    localparam int SQRT_STEPS        = 24;
    localparam int CNT_W             = $clog2(TABLE_LEN);

    // Angle limits in Q9.8 degrees
    localparam int ANG_LIMIT         = 46080;
    localparam int RIGHT_ANGLE_Q8    = 23040;

    // Register width and index
    localparam int CFG_IDX_W         = 8;
    localparam int CFG_W             = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GYRO_GAIN      = 8'd0,
        CFG_OFFSET_ROLL    = 8'd1,
        CFG_OFFSET_PITCH   = 8'd2,
        CFG_BLEND_WEIGHT   = 8'd3
    } cfg_idx_t;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQA,
        OP_SQB,
        OP_SUM,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_CORDIC_INIT,
        OP_CORDIC_STEP,
        OP_TILT,
        OP_RMUL,
        OP_RATE,
        OP_DTMUL,
        OP_GPATH,
        OP_BWMUL,
        OP_BTMUL,
        OP_BLEND,
        OP_EMIT
    } op_t;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQA,
        ST_SQB,
        ST_SUM,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_CORDIC_INIT,
        ST_CORDIC,
        ST_TILT,
        ST_RMUL,
        ST_RATE,
        ST_DTMUL,
        ST_GPATH,
        ST_BWMUL,
        ST_BTMUL,
        ST_BLEND,
        ST_EMIT
    } state_t;

    typedef struct packed {
        op_t              op;
        logic             axis;   // 0 roll, 1 pitch
        logic [CNT_W-1:0] iter;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_flags_t;

    // atan(2^-i) in degrees, Q.16
    function automatic logic [21:0] atan_lut(input logic [CNT_W-1:0] i);
        logic [21:0] r;
        begin
            case (i)
                5'd0:    r = 22'd2949120;
                5'd1:    r = 22'd1740967;
                5'd2:    r = 22'd919879;
                5'd3:    r = 22'd466945;
                5'd4:    r = 22'd234379;
                5'd5:    r = 22'd117304;
                5'd6:    r = 22'd58666;
                5'd7:    r = 22'd29335;
                5'd8:    r = 22'd14668;
                5'd9:    r = 22'd7334;
                5'd10:   r = 22'd3667;
                5'd11:   r = 22'd1833;
                5'd12:   r = 22'd917;
                5'd13:   r = 22'd458;
                5'd14:   r = 22'd229;
                5'd15:   r = 22'd115;
                5'd16:   r = 22'd57;
                5'd17:   r = 22'd29;
                5'd18:   r = 22'd14;
                5'd19:   r = 22'd7;
                5'd20:   r = 22'd4;
                5'd21:   r = 22'd2;
                5'd22:   r = 22'd1;
                default: r = 22'd0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/imu_tilt_complementary_filter_top.sv =====
// ----------------------------------------------------------------------------
// imu_tilt_complementary_filter_top
// Roll and pitch complementary filter with CORDIC accelerometer tilt.
// ----------------------------------------------------------------------------
// Each axis runs the bit-serial root and then the CORDIC for its tilt; both axes then run
// the gyro integration and the blend. Input is taken only when idle, so a new sample waits
// until the previous result has been emitted.
// Reset clears the estimates to zero degrees and loads the register defaults.
`default_nettype none

module imu_tilt_complementary_filter_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, time_step (low bits up)
    input  wire logic [95:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // roll_angle [16:0], pitch_angle [33:17], zero pad
    output logic [39:0]      m_axis_tdata,
    input  wire logic        cfg_wen,
    input  wire logic [imutcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [imutcf_pkg::CFG_W-1:0]     cfg_wdata
);
    import imutcf_pkg::*;

    cmd_t      cmd;
    dp_flags_t status;

    imutcf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    imutcf_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_tdata   (s_axis_tdata),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .out_tvalid (m_axis_tvalid),
        .out_tready (m_axis_tready),
        .out_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/core/imutcf_ctrl.sv =====
// ----------------------------------------------------------------------------
// imutcf_ctrl
// Sequencer: steps the datapath through tilt, gyro integration and blend.
// ----------------------------------------------------------------------------
`default_nettype none

module imutcf_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_tvalid,
    output logic                   in_tready,
    input  wire imutcf_pkg::dp_flags_t status,
    output imutcf_pkg::cmd_t       cmd
);
    import imutcf_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             axis_reg, axis_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        in_tready  = 1'b0;
        cmd.op     = OP_NONE;
        cmd.axis   = axis_reg;
        cmd.iter   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_tready = 1'b1;
                if (in_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    axis_next  = 1'b0;
                    state_next = ST_SQA;
                end
            end
            ST_SQA:
            begin
                cmd.op     = OP_SQA;
                state_next = ST_SQB;
            end
            ST_SQB:
            begin
                cmd.op     = OP_SQB;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.op     = OP_SUM;
                state_next = ST_SQRT_INIT;
            end
            ST_SQRT_INIT:
            begin
                cmd.op     = OP_SQRT_INIT;
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.op   = OP_SQRT_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    state_next = ST_CORDIC_INIT;
                end
            end
            ST_CORDIC_INIT:
            begin
                cmd.op     = OP_CORDIC_INIT;
                cnt_next   = '0;
                state_next = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                cmd.op   = OP_CORDIC_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                begin
                    state_next = ST_TILT;
                end
            end
            ST_TILT:
            begin
                cmd.op = OP_TILT;
                if (!axis_reg)
                begin
                    axis_next  = 1'b1;
                    state_next = ST_SQA;
                end
                else
                begin
                    axis_next  = 1'b0;
                    state_next = ST_RMUL;
                end
            end
            ST_RMUL:
            begin
                cmd.op     = OP_RMUL;
                state_next = ST_RATE;
            end
            ST_RATE:
            begin
                cmd.op     = OP_RATE;
                state_next = ST_DTMUL;
            end
            ST_DTMUL:
            begin
                cmd.op     = OP_DTMUL;
                state_next = ST_GPATH;
            end
            ST_GPATH:
            begin
                cmd.op     = OP_GPATH;
                state_next = ST_BWMUL;
            end
            ST_BWMUL:
            begin
                cmd.op     = OP_BWMUL;
                state_next = ST_BTMUL;
            end
            ST_BTMUL:
            begin
                cmd.op     = OP_BTMUL;
                state_next = ST_BLEND;
            end
            ST_BLEND:
            begin
                cmd.op = OP_BLEND;
                if (!axis_reg)
                begin
                    axis_next  = 1'b1;
                    state_next = ST_RMUL;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // hold until the output register is free
                if (status.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/imutcf_datapath.sv =====
// ----------------------------------------------------------------------------
// imutcf_datapath
// Registers, shared multiplier, bit-serial root, CORDIC and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module imutcf_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire imutcf_pkg::cmd_t    cmd,
    output imutcf_pkg::dp_flags_t    status,
    input  wire logic [95:0]         in_tdata,
    input  wire logic                cfg_wen,
    input  wire logic [imutcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [imutcf_pkg::CFG_W-1:0]     cfg_wdata,
    output logic                     out_tvalid,
    input  wire logic                out_tready,
    output logic [39:0]              out_tdata
);
    import imutcf_pkg::*;

    // Configuration
    logic [15:0]        gain_reg, weight_reg;
    logic signed [15:0] off_roll_reg, off_pitch_reg;

    // Captured sample
    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg;
    logic [15:0]        dt_reg;

    // Arithmetic
    logic signed [45:0] prod_reg, acc_reg;
    logic [31:0]        sumsq_reg;
    logic [47:0]        rad_reg;
    logic [26:0]        rem_reg;
    logic [23:0]        root_reg;
    logic signed [27:0] x_reg, y_reg;
    logic signed [24:0] z_reg;
    logic               zero_reg;
    logic signed [25:0] rate_reg;
    logic signed [27:0] gpath_reg;
    logic signed [16:0] tilt_roll_reg, tilt_pitch_reg;
    logic signed [16:0] est_roll_reg, est_pitch_reg;

    logic               out_valid_reg;
    logic [16:0]        out_roll_reg, out_pitch_reg;

    // Per-axis selections
    logic signed [15:0] sq_sel, num_sel, gyro_sel, off_sel;
    logic signed [16:0] est_sel, tilt_sel;

    assign sq_sel   = cmd.axis ? ay_reg : ax_reg;
    assign num_sel  = cmd.axis ? ax_reg : ay_reg;
    assign gyro_sel = cmd.axis ? gy_reg : gx_reg;
    assign off_sel  = cmd.axis ? off_pitch_reg : off_roll_reg;
    assign est_sel  = cmd.axis ? est_pitch_reg : est_roll_reg;
    assign tilt_sel = cmd.axis ? tilt_pitch_reg : tilt_roll_reg;

    // Shared multiplier operands
    logic signed [27:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [45:0] mul_p;
    logic [16:0]        tilt_w;

    assign tilt_w = 17'h10000 - {1'b0, weight_reg};

    always_comb
    begin
        mul_a = 28'sd0;
        mul_b = 18'sd0;
        case (cmd.op)
            OP_SQA:
            begin
                mul_a = 28'(sq_sel);
                mul_b = 18'(sq_sel);
            end
            OP_SQB:
            begin
                mul_a = 28'(az_reg);
                mul_b = 18'(az_reg);
            end
            OP_RMUL:
            begin
                mul_a = 28'(gyro_sel);
                mul_b = {2'b00, gain_reg};
            end
            OP_DTMUL:
            begin
                mul_a = 28'(rate_reg);
                mul_b = {2'b00, dt_reg};
            end
            OP_BWMUL:
            begin
                mul_a = gpath_reg;
                mul_b = {2'b00, weight_reg};
            end
            OP_BTMUL:
            begin
                mul_a = 28'(tilt_sel);
                mul_b = {1'b0, tilt_w};
            end
            default:
            begin
                mul_a = 28'sd0;
                mul_b = 18'sd0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Root step
    logic [26:0] rem_sh, trial;
    logic        fits;

    assign rem_sh = {rem_reg[24:0], rad_reg[47:46]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    // CORDIC step
    logic signed [27:0] xs, ys;
    logic signed [24:0] atan_v;

    assign xs     = x_reg >>> cmd.iter;
    assign ys     = y_reg >>> cmd.iter;
    assign atan_v = 25'(atan_lut(cmd.iter));

    // Rounding and clamp
    logic signed [45:0] rate_rnd, delta_rnd, blend_rnd;
    logic signed [45:0] blend_sum;
    logic signed [25:0] rate_sum;
    logic signed [27:0] gpath_sum;
    logic signed [24:0] z_rnd;
    logic signed [16:0] tilt_v, blend_v;
    logic signed [29:0] blend_q;

    assign rate_rnd  = (prod_reg + 46'sd128) >>> 8;
    assign rate_sum  = $signed(rate_rnd[25:0]) + 26'(off_sel);
    assign delta_rnd = (prod_reg + 46'sd32768) >>> 16;
    assign gpath_sum = $signed(delta_rnd[27:0]) + 28'(est_sel);
    assign blend_sum = acc_reg + prod_reg;
    assign blend_rnd = (blend_sum + 46'sd32768) >>> 16;
    assign blend_q   = blend_rnd[29:0];
    assign z_rnd     = (z_reg + 25'sd128) >>> 8;

    always_comb
    begin
        if (zero_reg)
        begin
            if (num_sel > 16'sd0)
                tilt_v = 17'(RIGHT_ANGLE_Q8);
            else if (num_sel < 16'sd0)
                tilt_v = -17'(RIGHT_ANGLE_Q8);
            else
                tilt_v = 17'sd0;
        end
        else
        begin
            tilt_v = z_rnd[16:0];
        end
    end

    always_comb
    begin
        if (blend_q > 30'(ANG_LIMIT))
            blend_v = 17'(ANG_LIMIT);
        else if (blend_q < -30'(ANG_LIMIT))
            blend_v = -17'(ANG_LIMIT);
        else
            blend_v = blend_q[16:0];
    end

    // Configuration and estimates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= 16'd500;
            off_roll_reg  <= 16'sd647;
            off_pitch_reg <= -16'sd289;
            weight_reg    <= 16'd52429;
            est_roll_reg  <= 17'sd0;
            est_pitch_reg <= 17'sd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    CFG_GYRO_GAIN:    gain_reg      <= cfg_wdata;
                    CFG_OFFSET_ROLL:  off_roll_reg  <= cfg_wdata;
                    CFG_OFFSET_PITCH: off_pitch_reg <= cfg_wdata;
                    CFG_BLEND_WEIGHT: weight_reg    <= cfg_wdata;
                    default:          ;
                endcase
            end
            if (cmd.op == OP_BLEND)
            begin
                if (cmd.axis)
                    est_pitch_reg <= blend_v;
                else
                    est_roll_reg <= blend_v;
            end
            // drop the result once taken, raise it on emit
            if (cmd.op == OP_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                ax_reg <= in_tdata[15:0];
                ay_reg <= in_tdata[31:16];
                az_reg <= in_tdata[47:32];
                gx_reg <= in_tdata[63:48];
                gy_reg <= in_tdata[79:64];
                dt_reg <= in_tdata[95:80];
            end
            OP_SQA, OP_RMUL, OP_DTMUL, OP_BWMUL:
            begin
                prod_reg <= mul_p;
            end
            OP_SQB:
            begin
                sumsq_reg <= prod_reg[31:0];
                prod_reg  <= mul_p;
            end
            OP_SUM:
            begin
                sumsq_reg <= sumsq_reg + prod_reg[31:0];
            end
            OP_SQRT_INIT:
            begin
                rad_reg  <= {sumsq_reg, 16'h0000};
                rem_reg  <= '0;
                root_reg <= '0;
            end
            OP_SQRT_STEP:
            begin
                rad_reg <= {rad_reg[45:0], 2'b00};
                if (fits)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[22:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[22:0], 1'b0};
                end
            end
            OP_CORDIC_INIT:
            begin
                x_reg    <= {4'b0000, root_reg};
                y_reg    <= {{4{num_sel[15]}}, num_sel, 8'h00};
                z_reg    <= 25'sd0;
                zero_reg <= (root_reg == 24'd0);
            end
            OP_CORDIC_STEP:
            begin
                // rotate towards the x axis
                if (y_reg >= 28'sd0)
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_v;
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_v;
                end
            end
            OP_TILT:
            begin
                if (cmd.axis)
                    tilt_pitch_reg <= tilt_v;
                else
                    tilt_roll_reg <= tilt_v;
            end
            OP_RATE:
            begin
                rate_reg <= rate_sum;
            end
            OP_GPATH:
            begin
                gpath_reg <= gpath_sum;
            end
            OP_BTMUL:
            begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            OP_EMIT:
            begin
                out_roll_reg  <= est_roll_reg;
                out_pitch_reg <= est_pitch_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status.out_free = !out_valid_reg || out_tready;
    assign out_tvalid      = out_valid_reg;
    assign out_tdata       = {6'b000000, out_pitch_reg, out_roll_reg};

    // Checks
    a_est_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (est_roll_reg <= 17'(ANG_LIMIT)) && (est_roll_reg >= -17'(ANG_LIMIT)) &&
        (est_pitch_reg <= 17'(ANG_LIMIT)) && (est_pitch_reg >= -17'(ANG_LIMIT)))
        else $error("estimate beyond angle limit");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT) |=> out_valid_reg)
        else $error("emit did not raise output valid");

    a_cordic_x_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_CORDIC_STEP && !zero_reg) |-> (x_reg > 28'sd0))
        else $error("CORDIC x lost its sign");

endmodule

`default_nettype wire
